>>> hw/rtl/scfd_pkg.sv
// Shared constants, codes and CRC helper for the sync/CRC frame deframer.
package scfd_pkg;

  // Frame layout
  localparam int HEADER_BYTES = 28;
  localparam int POS_W = 17;
  localparam logic [POS_W-1:0] HDR_LEN = POS_W'(HEADER_BYTES);
  localparam logic [POS_W-1:0] ID_LO_OFF = 17'd4;
  localparam logic [POS_W-1:0] ID_HI_OFF = 17'd5;
  localparam logic [POS_W-1:0] LEN_LO_OFF = 17'd8;
  localparam logic [POS_W-1:0] LEN_HI_OFF = 17'd9;
  localparam logic [POS_W-1:0] SYNC_LEN = 17'd3;

  // Sync word
  localparam logic [7:0] SYNC_B0 = 8'hAA;
  localparam logic [7:0] SYNC_B1 = 8'h44;
  localparam logic [7:0] SYNC_B2 = 8'h12;

  // Parse phases
  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_HEAD = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;
  localparam logic [1:0] PH_CRC  = 2'd3;

  // Dispatch classes
  localparam logic [2:0] CLS_OBS   = 3'd0;
  localparam logic [2:0] CLS_GPSEPH = 3'd1;
  localparam logic [2:0] CLS_POS   = 3'd2;
  localparam logic [2:0] CLS_BDSEPH = 3'd3;
  localparam logic [2:0] CLS_OTHER = 3'd4;

  localparam logic [15:0] ID_OBS    = 16'd43;
  localparam logic [15:0] ID_GPSEPH = 16'd7;
  localparam logic [15:0] ID_POS    = 16'd42;
  localparam logic [15:0] ID_BDSEPH = 16'd1696;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  // Reflected CRC-32, one byte, unrolled over eight bit steps
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // CRC state right after the three sync bytes
  localparam logic [31:0] CRC_AFTER_SYNC =
    crc_byte(crc_byte(crc_byte(32'd0, SYNC_B0), SYNC_B1), SYNC_B2);

  function automatic logic [2:0] class_of(input logic [15:0] id);
    logic [2:0] cls;
    if (id == ID_OBS) cls = CLS_OBS;
    else if (id == ID_GPSEPH) cls = CLS_GPSEPH;
    else if (id == ID_POS) cls = CLS_POS;
    else if (id == ID_BDSEPH) cls = CLS_BDSEPH;
    else cls = CLS_OTHER;
    return cls;
  endfunction

endpackage

>>> hw/rtl/scfd_if.sv
// Valid/ready channel interfaces for the deframer input and output items.
interface scfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scfd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [16:0] frame_offset;
  logic        in_body;
  logic        frame_done;
  logic        crc_ok;
  logic [15:0] msg_id;
  logic [2:0]  message_class;
  logic [15:0] body_length;

  modport source (output valid, output out_byte, output frame_offset, output in_body,
                  output frame_done, output crc_ok, output msg_id,
                  output message_class, output body_length, input ready);
  modport sink   (input valid, input out_byte, input frame_offset, input in_body,
                  input frame_done, input crc_ok, input msg_id,
                  input message_class, input body_length, output ready);
endinterface

>>> hw/rtl/sync_crc_frame_deframer_top.sv
// Top level of the sync-word, length-framed deframer with CRC-32 check.
//
//  channel | dir | payload                                   | handshake
//  din     | in  | rx_byte                                   | valid/ready
//  dout    | out | out_byte, frame_offset, in_body,          | valid/ready
//          |     | frame_done, crc_ok, msg_id,               |
//          |     | message_class, body_length                |
//
// One byte per cycle unless the output stalls: each item is parsed between the
// parser state and the output register, the byte-wide CRC update being the
// longest path. Result appears in the cycle after the byte is taken; sync bytes
// give no result. rst (synchronous) returns the parser to sync hunting.
// A stalled output holds its item; din stays ready as long as the output
// register is empty or being drained in the same cycle.
module sync_crc_frame_deframer_top
  import scfd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  scfd_in_if.sink    din,
  scfd_out_if.source dout
);

  // Parser state
  logic [15:0]      sync_hist, sync_hist_next;
  logic [1:0]       phase, phase_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [15:0]      held_id, held_id_next;
  logic [15:0]      held_len, held_len_next;
  logic [31:0]      run_crc, run_crc_next;
  logic [31:0]      rcv_crc, rcv_crc_next;

  // Output register
  logic        out_valid;
  logic [7:0]  o_byte;
  logic [16:0] o_off;
  logic        o_body, o_done, o_ok;
  logic [15:0] o_id, o_len;
  logic [2:0]  o_cls;

  logic             take;
  logic             emit;
  logic [7:0]       b;
  logic             hit;
  logic [31:0]      crc_upd;
  logic [1:0]       crc_k;
  logic             is_body, is_done, is_ok;
  logic [15:0]      id_out, len_out;
  logic [POS_W:0]   body_end;

  assign din.ready = !out_valid || dout.ready;
  assign take = din.valid && din.ready;
  assign b = din.rx_byte;
  assign crc_upd = crc_byte(run_crc, b);
  assign hit = (sync_hist == {SYNC_B0, SYNC_B1}) && (b == SYNC_B2);
  assign crc_k = pos[1:0] - HDR_LEN[1:0] - held_len[1:0];
  assign body_end = {1'b0, HDR_LEN} + {{(POS_W-15){1'b0}}, held_len};

  // Per-byte parse
  always_comb begin
    sync_hist_next = sync_hist;
    phase_next = phase;
    pos_next = pos;
    held_id_next = held_id;
    held_len_next = held_len;
    run_crc_next = run_crc;
    rcv_crc_next = rcv_crc;
    emit = 1'b0;
    is_body = 1'b0;
    is_done = 1'b0;
    is_ok = 1'b0;
    case (phase)
      PH_HUNT: begin
        sync_hist_next = {sync_hist[7:0], b};
        if (hit) begin
          run_crc_next = CRC_AFTER_SYNC;
          rcv_crc_next = 32'd0;
          held_id_next = 16'd0;
          held_len_next = 16'd0;
          pos_next = SYNC_LEN;
          phase_next = PH_HEAD;
        end
      end
      PH_HEAD: begin
        emit = 1'b1;
        run_crc_next = crc_upd;
        if (pos == ID_LO_OFF) held_id_next[7:0] = b;
        if (pos == ID_HI_OFF) held_id_next[15:8] = b;
        if (pos == LEN_LO_OFF) held_len_next[7:0] = b;
        if (pos == LEN_HI_OFF) held_len_next[15:8] = b;
        if (pos >= HDR_LEN - 17'd1) begin
          phase_next = (held_len_next != 16'd0) ? PH_BODY : PH_CRC;
        end
      end
      PH_BODY: begin
        emit = 1'b1;
        is_body = 1'b1;
        run_crc_next = crc_upd;
        if (({1'b0, pos} + 18'd1) >= body_end) phase_next = PH_CRC;
      end
      default: begin
        emit = 1'b1;
        case (crc_k)
          2'd0: rcv_crc_next[7:0]   = rcv_crc[7:0]   | b;
          2'd1: rcv_crc_next[15:8]  = rcv_crc[15:8]  | b;
          2'd2: rcv_crc_next[23:16] = rcv_crc[23:16] | b;
          default: rcv_crc_next[31:24] = rcv_crc[31:24] | b;
        endcase
        if (crc_k == 2'd3) begin
          is_done = 1'b1;
          is_ok = (run_crc == rcv_crc_next);
          phase_next = PH_HUNT;
          sync_hist_next = 16'd0;
        end
      end
    endcase
    if (phase != PH_HUNT) pos_next = pos + 17'd1;
  end

  assign id_out = (pos >= ID_HI_OFF) ? held_id_next : 16'd0;
  assign len_out = (pos >= LEN_HI_OFF) ? held_len_next : 16'd0;

  // Parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_hist <= 16'd0;
      phase <= PH_HUNT;
      pos <= '0;
      held_id <= 16'd0;
      held_len <= 16'd0;
      run_crc <= 32'd0;
      rcv_crc <= 32'd0;
    end else if (take) begin
      sync_hist <= sync_hist_next;
      phase <= phase_next;
      pos <= pos_next;
      held_id <= held_id_next;
      held_len <= held_len_next;
      run_crc <= run_crc_next;
      rcv_crc <= rcv_crc_next;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && emit) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (take && emit) begin
      o_byte <= b;
      o_off <= pos;
      o_body <= is_body;
      o_done <= is_done;
      o_ok <= is_ok;
      o_id <= id_out;
      o_cls <= class_of(id_out);
      o_len <= len_out;
    end
  end

  assign dout.valid = out_valid;
  assign dout.out_byte = o_byte;
  assign dout.frame_offset = o_off;
  assign dout.in_body = o_body;
  assign dout.frame_done = o_done;
  assign dout.crc_ok = o_ok;
  assign dout.msg_id = o_id;
  assign dout.message_class = o_cls;
  assign dout.body_length = o_len;

endmodule

>>> test/sync_crc_frame_deframer_top_tb.sv
// Self-checking testbench for the sync/CRC frame deframer: directed and random streams.
module sync_crc_frame_deframer_top_tb;
  import scfd_pkg::*;

  // One output item as the deframer should present it
  typedef struct packed {
    logic [7:0]  data;
    logic [16:0] offset;
    logic        body;
    logic        done;
    logic        ok;
    logic [15:0] id;
    logic [2:0]  cls;
    logic [15:0] len;
  } deframe_result_t;

  localparam int RANDOM_FRAME_BYTES = 250;
  localparam int DRAIN_LIMIT = 200000;
  localparam int TAIL_CYCLES = 4;

  logic clk;
  logic rst;

  scfd_in_if  din ();
  scfd_out_if dout ();

  sync_crc_frame_deframer_top u_dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout)
  );

  // Parser shadow state
  logic [15:0] hunt_hist;
  logic [1:0]  parse_ph;
  logic [16:0] next_pos;
  logic [15:0] cur_id;
  logic [15:0] cur_len;
  logic [31:0] crc_acc;
  logic [31:0] crc_rx;

  deframe_result_t expected_results[$];
  logic [7:0]      frame_buf[$];
  int              frame_base;
  int              mismatches;
  int              frame_bytes_sent;

  // Idle controls for the source gaps and the sink process
  bit src_idle_en;
  bit snk_idle_en;
  int hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("sync_crc_frame_deframer_top verification failed");
    $finish;
  end

  // Reflected CRC-32, processed one input bit at a time
  function automatic logic [31:0] crc32_update(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic logic [2:0] dispatch_class(input logic [15:0] id);
    logic [2:0] cls;
    case (id)
      ID_OBS:    cls = CLS_OBS;
      ID_GPSEPH: cls = CLS_GPSEPH;
      ID_POS:    cls = CLS_POS;
      ID_BDSEPH: cls = CLS_BDSEPH;
      default:   cls = CLS_OTHER;
    endcase
    return cls;
  endfunction

  // Advance the shadow parser by one accepted byte and queue its result
  task automatic predict_byte(input logic [7:0] b);
    deframe_result_t r;
    logic [16:0]     off;
    logic [16:0]     crc_idx;
    logic [15:0]     id_seen;
    if (parse_ph == PH_HUNT) begin
      if (hunt_hist == {SYNC_B0, SYNC_B1} && b == SYNC_B2) begin
        crc_acc = crc32_update(crc32_update(crc32_update(32'd0, SYNC_B0), SYNC_B1), SYNC_B2);
        crc_rx = '0;
        cur_id = '0;
        cur_len = '0;
        next_pos = SYNC_LEN;
        parse_ph = PH_HEAD;
      end
      hunt_hist = {hunt_hist[7:0], b};
    end else begin
      off = next_pos;
      r = '0;
      case (parse_ph)
        PH_HEAD: begin
          crc_acc = crc32_update(crc_acc, b);
          if (off == ID_LO_OFF) cur_id[7:0] = b;
          if (off == ID_HI_OFF) cur_id[15:8] = b;
          if (off == LEN_LO_OFF) cur_len[7:0] = b;
          if (off == LEN_HI_OFF) cur_len[15:8] = b;
          if (off >= HDR_LEN - 17'd1) parse_ph = (cur_len != 0) ? PH_BODY : PH_CRC;
        end
        PH_BODY: begin
          r.body = 1'b1;
          crc_acc = crc32_update(crc_acc, b);
          if (off >= HDR_LEN + {1'b0, cur_len} - 17'd1) parse_ph = PH_CRC;
        end
        default: begin
          crc_idx = off - HDR_LEN - {1'b0, cur_len};
          crc_rx[8*crc_idx[1:0] +: 8] = b;
          if (crc_idx[1:0] == 2'd3) begin
            r.done = 1'b1;
            r.ok = (crc_acc == crc_rx);
            parse_ph = PH_HUNT;
            hunt_hist = '0;
          end
        end
      endcase
      next_pos = off + 17'd1;
      id_seen = (off >= ID_HI_OFF) ? cur_id : 16'd0;
      r.data = b;
      r.offset = off;
      r.id = id_seen;
      r.cls = dispatch_class(id_seen);
      r.len = (off >= LEN_HI_OFF) ? cur_len : 16'd0;
      expected_results.push_back(r);
    end
  endtask

  function automatic void check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Result checker
  initial begin : result_checker
    deframe_result_t want;
    forever begin
      @(posedge clk);
      if (!rst && dout.valid && dout.ready) begin
        if (expected_results.size() == 0) begin
          $error("out_byte: unexpected item 0x%0h at offset %0d", dout.out_byte,
                 dout.frame_offset);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("out_byte", want.data, dout.out_byte);
          check_field("frame_offset", want.offset, dout.frame_offset);
          check_field("in_body", want.body, dout.in_body);
          check_field("frame_done", want.done, dout.frame_done);
          check_field("crc_ok", want.ok, dout.crc_ok);
          check_field("msg_id", want.id, dout.msg_id);
          check_field("message_class", want.cls, dout.message_class);
          check_field("body_length", want.len, dout.body_length);
        end
      end
    end
  end

  // Output ready: long holds on request, otherwise random stalls while snk_idle_en is set
  initial begin : sink_ready_gen
    int stall_left;
    stall_left = 0;
    dout.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        dout.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        dout.ready <= 1'b0;
        stall_left--;
      end else if (snk_idle_en && $urandom_range(0, 99) < 20) begin
        stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(10, 50);
        dout.ready <= 1'b0;
      end else begin
        dout.ready <= 1'b1;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (!src_idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b, input int gap);
    for (int i = 0; i < gap; i++) begin
      @(negedge clk);
      din.valid <= 1'b0;
    end
    @(negedge clk);
    din.valid <= 1'b1;
    din.rx_byte <= b;
    do @(posedge clk); while (!din.ready);
    predict_byte(b);
  endtask

  task automatic stop_input();
    @(negedge clk);
    din.valid <= 1'b0;
  endtask

  task automatic send_buf(input bit count_frame);
    foreach (frame_buf[i]) send_byte(frame_buf[i], pick_gap());
    if (count_frame) frame_bytes_sent += frame_buf.size();
    frame_buf.delete();
  endtask

  task automatic wait_results_drained();
    int guard;
    guard = 0;
    while (expected_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (expected_results.size() != 0) begin
      $error("frame_done: %0d items never arrived", expected_results.size());
      mismatches++;
      expected_results.delete();
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Append sync, header and body; CRC comes from seal_frame
  task automatic open_frame(input logic [15:0] id, input logic [15:0] len);
    frame_base = frame_buf.size();
    frame_buf.push_back(SYNC_B0);
    frame_buf.push_back(SYNC_B1);
    frame_buf.push_back(SYNC_B2);
    for (int i = SYNC_LEN; i < HEADER_BYTES; i++) begin
      if (i == ID_LO_OFF) frame_buf.push_back(id[7:0]);
      else if (i == ID_HI_OFF) frame_buf.push_back(id[15:8]);
      else if (i == LEN_LO_OFF) frame_buf.push_back(len[7:0]);
      else if (i == LEN_HI_OFF) frame_buf.push_back(len[15:8]);
      else frame_buf.push_back(8'($urandom_range(0, 255)));
    end
    for (int i = 0; i < len; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic seal_frame(input bit corrupt);
    logic [31:0] c;
    int          n;
    c = 32'd0;
    n = frame_buf.size();
    for (int i = frame_base; i < n; i++) c = crc32_update(c, frame_buf[i]);
    if (corrupt) c[$urandom_range(0, 31)] = ~c[$urandom_range(0, 31)] ^ 1'b1 ^ c[0] ^ c[0];
    if (corrupt && c == crc32_calc_frame()) c = ~c;
    for (int k = 0; k < 4; k++) frame_buf.push_back(c[8*k +: 8]);
  endtask

  function automatic logic [31:0] crc32_calc_frame();
    logic [31:0] c;
    c = 32'd0;
    for (int i = frame_base; i < frame_buf.size(); i++) c = crc32_update(c, frame_buf[i]);
    return c;
  endfunction

  task automatic push_noise(input int n);
    for (int i = 0; i < n; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  // Sync hunting: noise, broken and overlapping syncs, zero-length body
  task automatic test_sync_hunt();
    frame_buf = '{8'h00, 8'hFF, SYNC_B0, SYNC_B1, 8'h00, SYNC_B1, SYNC_B2, SYNC_B0};
    open_frame(ID_OBS, 16'd0);
    seal_frame(1'b0);
    send_buf(1'b1);
    frame_buf = '{SYNC_B0, SYNC_B1};
    open_frame(16'hFFFF, 16'd1);
    seal_frame(1'b0);
    send_buf(1'b1);
    stop_input();
    wait_results_drained();
  endtask

  // Every dispatch class but observation, plus one corrupted CRC
  task automatic test_dispatch_classes();
    open_frame(ID_GPSEPH, 16'd3);
    seal_frame(1'b0);
    open_frame(ID_POS, 16'd2);
    seal_frame(1'b0);
    open_frame(ID_BDSEPH, 16'd5);
    seal_frame(1'b0);
    open_frame(16'h0000, 16'd4);
    seal_frame(1'b1);
    send_buf(1'b1);
    stop_input();
    wait_results_drained();
  endtask

  // Sync inside a frame and across a frame end must not start a new frame
  task automatic test_frame_boundaries();
    open_frame(ID_OBS, 16'd6);
    frame_buf[HEADER_BYTES + 1] = SYNC_B0;
    frame_buf[HEADER_BYTES + 2] = SYNC_B1;
    frame_buf[HEADER_BYTES + 3] = SYNC_B2;
    seal_frame(1'b0);
    open_frame(ID_POS, 16'd2);
    for (int k = 0; k < 2; k++) frame_buf.push_back(8'($urandom_range(0, 255)));
    frame_buf.push_back(SYNC_B0);
    frame_buf.push_back(SYNC_B1);
    frame_buf.push_back(SYNC_B2);
    push_noise(3);
    open_frame(ID_GPSEPH, 16'd0);
    seal_frame(1'b0);
    send_buf(1'b1);
    stop_input();
    wait_results_drained();
  endtask

  // Output held off while input keeps coming, then the sender waits for a full drain
  task automatic test_backpressure();
    src_idle_en = 1'b0;
    hold_left = 300;
    open_frame(ID_BDSEPH, 16'd40);
    seal_frame(1'b0);
    send_buf(1'b1);
    stop_input();
    wait_results_drained();
    src_idle_en = 1'b1;
    open_frame(ID_OBS, 16'd12);
    seal_frame(1'b0);
    send_buf(1'b1);
    stop_input();
    wait_results_drained();
  endtask

  // Mostly well-formed frames, with bad CRCs, noise and sync fragments mixed in
  task automatic test_random_stream();
    int          pick;
    logic [15:0] id;
    logic [15:0] len;
    logic [7:0]  tail;
    while (frame_bytes_sent < RANDOM_FRAME_BYTES) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 15) begin
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
      end else begin
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
      end
      if (pick < 80) begin
        case ($urandom_range(0, 7))
          0: id = ID_OBS;
          1: id = ID_GPSEPH;
          2: id = ID_POS;
          3: id = ID_BDSEPH;
          default: id = 16'($urandom_range(0, 65535));
        endcase
        len = 16'(($urandom_range(0, 99) < 60) ? $urandom_range(0, 8) :
                  ($urandom_range(0, 99) < 75) ? $urandom_range(9, 40) :
                  $urandom_range(41, 300));
        open_frame(id, len);
        seal_frame(pick >= 70);
        send_buf(1'b1);
      end else if (pick < 90) begin
        push_noise($urandom_range(1, 12));
        send_buf(1'b0);
      end else begin
        frame_buf.push_back(SYNC_B0);
        if ($urandom_range(0, 1)) frame_buf.push_back(SYNC_B1);
        tail = 8'($urandom_range(0, 254));
        if (tail == SYNC_B2) tail = tail + 8'd1;
        frame_buf.push_back(tail);
        send_buf(1'b0);
      end
    end
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    stop_input();
    wait_results_drained();
  endtask

  initial begin
    hunt_hist = '0;
    parse_ph = PH_HUNT;
    next_pos = '0;
    cur_id = '0;
    cur_len = '0;
    crc_acc = '0;
    crc_rx = '0;
    mismatches = 0;
    frame_bytes_sent = 0;
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    hold_left = 0;
    din.valid = 1'b0;
    din.rx_byte = 8'h00;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_sync_hunt();
    test_dispatch_classes();
    test_frame_boundaries();
    test_backpressure();
    frame_bytes_sent = 0;
    test_random_stream();

    if (expected_results.size() != 0) begin
      $error("frame_done: %0d items left over", expected_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("sync_crc_frame_deframer_top verification clean");
    end else begin
      $display("sync_crc_frame_deframer_top verification failed");
    end
    $finish;
  end

endmodule
